@@ rtl/kflp_pkg.sv @@
// Package for the keyframe LED fade player.
// Holds the word types, command codes and fixed field widths.
// No dependencies.
package kflp_pkg;

    localparam int TW = 31;

    localparam logic [1:0] CMD_HDR   = 2'd0;
    localparam logic [1:0] CMD_COL   = 2'd1;
    localparam logic [1:0] CMD_LOOK  = 2'd2;
    localparam logic [1:0] CMD_BLANK = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         frame_index;
        logic [30:0]        frame_start_ms;
        logic               fade_enable;
        logic [4:0]         channel_index;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic signed [31:0] query_time_ms;
    } t_in_word;

    typedef struct packed {
        logic [4:0]  channel;
        logic [31:0] packed_color;
        logic [7:0]  found_frame;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic       start;
        logic [7:0] c0;
        logic [7:0] c1;
    } t_mix_req;

    typedef struct packed {
        logic       done;
        logic [7:0] value;
    } t_mix_rsp;

endpackage

@@ rtl/keyframe_led_fade_player.sv @@
// Lookup: a scan of the headers of the frames in use (skipped for a time at or below zero),
// header reads (a second one on a fade frame), then per channel the colour reads and, on a
// fade frame, four component mixes (one shared mixer); a blank run one word per channel.
// One item at a time, bounded by the header and colour RAM read ports and output stalls.
// Synchronous active-low reset clears control state; the RAMs are not cleared.
// Depends on kflp_pkg, kflp_ram and kflp_mix.
module keyframe_led_fade_player #(
    parameter int FRAMES   = 256,
    parameter int CHANNELS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  kflp_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output kflp_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [8:0]          i_cfg_data
);
    localparam int FW  = $clog2(FRAMES);
    localparam int NW  = $clog2(FRAMES + 1);
    localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW  = $clog2(FRAMES * CHANNELS);
    localparam int TW  = kflp_pkg::TW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_H0   = 4'd2;
    localparam logic [3:0] S_H0W  = 4'd3;
    localparam logic [3:0] S_H1W  = 4'd4;
    localparam logic [3:0] S_ND   = 4'd5;
    localparam logic [3:0] S_CA   = 4'd6;
    localparam logic [3:0] S_CB   = 4'd7;
    localparam logic [3:0] S_CBW  = 4'd8;
    localparam logic [3:0] S_MST  = 4'd9;
    localparam logic [3:0] S_MIX  = 4'd10;
    localparam logic [3:0] S_EMIT = 4'd11;

    logic [3:0]         r_state;
    logic [3:0]         n_state;
    logic [8:0]         r_count;
    logic signed [31:0] r_t;
    logic [NW-1:0]      r_n;
    logic [NW-1:0]      r_idx;
    logic [FW-1:0]      r_f;
    logic [FW-1:0]      r_pidx;
    logic               r_pend;
    logic               r_fade;
    logic               r_zero;
    logic [TW-1:0]      r_s0;
    logic signed [31:0] r_d;
    logic signed [32:0] r_e;
    logic [TW-1:0]      r_num;
    logic [TW-1:0]      r_den;
    logic [CIW-1:0]     r_ch;
    logic [1:0]         r_comp;
    logic [31:0]        r_ca;
    logic [31:0]        r_cb;
    logic [31:0]        r_color;
    logic               r_ovalid;
    kflp_pkg::t_out_word r_out;

    logic               in_fire;
    logic               out_free;
    logic               ch_last;
    logic               has_next;
    logic [NW-1:0]      n_lim;
    logic               hdr_we;
    logic               col_we;
    logic [FW-1:0]      hdr_raddr;
    logic [AW-1:0]      col_raddr;
    logic [31:0]        hdr_rdata;
    logic [31:0]        col_rdata;
    kflp_pkg::t_mix_req mix_req;
    kflp_pkg::t_mix_rsp mix_rsp;

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free   = !r_ovalid || i_out_ready;
    assign ch_last    = (32'(r_ch) == CHANNELS - 1);
    assign has_next   = ((NW + 1)'(r_f) + (NW + 1)'(1)) < (NW + 1)'(r_n);
    assign n_lim      = (32'(r_count) > FRAMES) ? NW'(FRAMES) : NW'(r_count);
    assign hdr_we     = in_fire && (i_in_word.cmd == kflp_pkg::CMD_HDR)
                        && (32'(i_in_word.frame_index) < FRAMES);
    assign col_we     = in_fire && (i_in_word.cmd == kflp_pkg::CMD_COL)
                        && (32'(i_in_word.frame_index) < FRAMES)
                        && (32'(i_in_word.channel_index) < CHANNELS);

    always_comb begin
        unique case (r_state)
            S_SCAN:  hdr_raddr = r_idx[FW-1:0];
            S_H0W:   hdr_raddr = FW'(32'(r_f) + 1);
            default: hdr_raddr = r_f;
        endcase
        if (r_state == S_CB) begin
            col_raddr = AW'((32'(r_f) + 1) * CHANNELS + 32'(r_ch));
        end else begin
            col_raddr = AW'(32'(r_f) * CHANNELS + 32'(r_ch));
        end
        mix_req.start = (r_state == S_MST);
        mix_req.c0    = r_ca[8 * (3 - r_comp) +: 8];
        mix_req.c1    = r_cb[8 * (3 - r_comp) +: 8];
    end

    kflp_ram #(.W(32), .D(FRAMES)) u_hdr_ram (
        .i_clk   (i_clk),
        .i_we    (hdr_we),
        .i_waddr (FW'(i_in_word.frame_index)),
        .i_wdata ({i_in_word.fade_enable, i_in_word.frame_start_ms}),
        .i_raddr (hdr_raddr),
        .o_rdata (hdr_rdata)
    );

    kflp_ram #(.W(32), .D(FRAMES * CHANNELS)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (AW'(32'(i_in_word.frame_index) * CHANNELS
                      + 32'(i_in_word.channel_index))),
        .i_wdata ({i_in_word.red, i_in_word.green, i_in_word.blue, i_in_word.alpha}),
        .i_raddr (col_raddr),
        .o_rdata (col_rdata)
    );

    kflp_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mix_req),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_rsp   (mix_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (i_in_word.cmd == kflp_pkg::CMD_BLANK)) begin
                    n_state = S_EMIT;
                end else if (in_fire && (i_in_word.cmd == kflp_pkg::CMD_LOOK)) begin
                    if (n_lim == '0) begin
                        n_state = S_EMIT;
                    end else if (i_in_word.query_time_ms <= 0) begin
                        n_state = S_H0;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN:  if (r_idx == r_n && !r_pend) n_state = S_H0;
            S_H0:    n_state = S_H0W;
            S_H0W:   n_state = (hdr_rdata[31] && has_next) ? S_H1W : S_CA;
            S_H1W:   n_state = S_ND;
            S_ND:    n_state = S_CA;
            S_CA:    n_state = S_CB;
            S_CB:    n_state = r_fade ? S_CBW : S_EMIT;
            S_CBW:   n_state = S_MST;
            S_MST:   n_state = S_MIX;
            S_MIX: begin
                if (mix_rsp.done) begin
                    n_state = (r_comp == 2'd3) ? S_EMIT : S_MST;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = ch_last ? S_IDLE : (r_zero ? S_EMIT : S_CA);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= 9'd0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
            if (r_state == S_EMIT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            r_pend <= (r_state == S_SCAN) && (r_idx < r_n);
        end

        unique case (r_state)
            S_IDLE: begin
                r_t    <= i_in_word.query_time_ms;
                r_n    <= n_lim;
                r_idx  <= '0;
                r_f    <= '0;
                r_ch   <= '0;
                r_fade <= 1'b0;
                r_zero <= (i_in_word.cmd == kflp_pkg::CMD_BLANK) || (n_lim == '0);
            end
            S_SCAN: begin
                if (r_idx < r_n) begin
                    r_idx  <= r_idx + NW'(1);
                    r_pidx <= r_idx[FW-1:0];
                end
                if (r_pend && ($signed({1'b0, hdr_rdata[30:0]}) <= r_t)) begin
                    r_f <= r_pidx;
                end
            end
            S_H0W: begin
                r_s0   <= hdr_rdata[30:0];
                r_fade <= hdr_rdata[31] && has_next;
            end
            S_H1W: begin
                r_d <= $signed({1'b0, hdr_rdata[30:0]}) - $signed({1'b0, r_s0});
                r_e <= 33'(r_t) - $signed({2'b00, r_s0});
            end
            S_ND: begin
                if (r_d <= 0) begin
                    r_den <= TW'(1);
                    r_num <= '0;
                end else begin
                    r_den <= r_d[TW-1:0];
                    if (r_e <= 0) begin
                        r_num <= '0;
                    end else if (r_e > 33'(r_d)) begin
                        r_num <= r_d[TW-1:0];
                    end else begin
                        r_num <= r_e[TW-1:0];
                    end
                end
            end
            S_CB: begin
                r_ca    <= col_rdata;
                r_color <= col_rdata;
            end
            S_CBW: begin
                r_cb   <= col_rdata;
                r_comp <= 2'd0;
            end
            S_MIX: begin
                if (mix_rsp.done) begin
                    r_color[8 * (3 - r_comp) +: 8] <= mix_rsp.value;
                    r_comp <= r_comp + 2'd1;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    r_out.channel      <= 5'(r_ch);
                    r_out.packed_color <= r_zero ? 32'd0 : r_color;
                    r_out.found_frame  <= r_zero ? 8'd0 : 8'(r_f);
                    r_out.last         <= ch_last;
                    r_ch               <= r_ch + CIW'(1);
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;
endmodule

@@ rtl/kflp_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module kflp_ram #(
    parameter int W = 32,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/kflp_mix.sv @@
// Interpolation unit: mixes one colour component, rounded half up.
// A multiply stage, a multiply-add stage and an eight-step restoring divider.
// Depends on kflp_pkg.
module kflp_mix (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  kflp_pkg::t_mix_req      i_req,
    input  logic [kflp_pkg::TW-1:0] i_num,
    input  logic [kflp_pkg::TW-1:0] i_den,
    output kflp_pkg::t_mix_rsp      o_rsp
);
    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_MAC  = 2'd1;
    localparam logic [1:0] M_DIV  = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [7:0]         r_c0;
    logic [7:0]         r_c1;
    logic [38:0]        r_p;
    logic [40:0]        r_rem;
    logic [40:0]        r_dsh;
    logic [7:0]         r_q;
    logic [7:0]         n_q;
    logic [2:0]         r_cnt;
    logic               r_done;
    logic signed [8:0]  diff;
    logic signed [40:0] prod;
    logic signed [41:0] x;

    always_comb begin
        diff = $signed({1'b0, r_c1}) - $signed({1'b0, r_c0});
        prod = $signed({{32{diff[8]}}, diff}) * $signed({10'b0, i_num});
        x    = $signed({3'b000, r_p}) + 42'(prod);
        n_q  = {r_q[6:0], (r_rem >= r_dsh)};
        n_state = r_state;
        unique case (r_state)
            M_IDLE:  if (i_req.start) n_state = M_MAC;
            M_MAC:   n_state = M_DIV;
            M_DIV:   if (r_cnt == 3'd7) n_state = M_IDLE;
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == M_DIV) && (r_cnt == 3'd7);
        end
        unique case (r_state)
            M_IDLE: begin
                r_c0 <= i_req.c0;
                r_c1 <= i_req.c1;
                r_p  <= {31'd0, i_req.c0} * {8'd0, i_den};
            end
            M_MAC: begin
                r_rem <= {x[39:0], 1'b0} + 41'(i_den);
                r_dsh <= {2'b00, i_den, 8'h00};
                r_cnt <= 3'd0;
                r_q   <= 8'd0;
            end
            M_DIV: begin
                if (r_rem >= r_dsh) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh <= r_dsh >> 1;
                r_q   <= n_q;
                r_cnt <= r_cnt + 3'd1;
            end
            default: ;
        endcase
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_q;
endmodule

@@ rtl/kflp_checker.sv @@
// Port-level checker for the keyframe LED fade player, with its bind.
// Depends on kflp_pkg and keyframe_led_fade_player.
module kflp_checker #(
    parameter int CHANNELS = 32
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input kflp_pkg::t_in_word  i_in_word,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input kflp_pkg::t_out_word o_out_word
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Output word dropped before it was taken.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output word valid straight after reset.");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.last == (32'(o_out_word.channel) == CHANNELS - 1)))
        else $error("Last flag does not match the final channel.");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_word.cmd[1] |=> !o_in_ready)
        else $error("Input accepted while a run was starting.");

    a_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.last |-> !o_in_ready)
        else $error("Input accepted in the middle of a run.");
endmodule

bind keyframe_led_fade_player kflp_checker #(.CHANNELS(CHANNELS)) u_kflp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
